// ----- rtl/core/iecf_pkg.sv -----
`default_nettype none

package iecf_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SIZE_BITS      = 14;
    localparam int OUT_BITS       = 17;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;

    // internal coordinate width: holds a coordinate flipped across an image edge
    localparam int WORK_BITS = ((COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1) + 2;
    localparam int MAG_BITS  = WORK_BITS - 1;

    // remainder pipeline: DIV_STEP restoring steps per register stage
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (MAG_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_BITS   = DIV_STAGES * DIV_STEP;

    localparam logic signed [WORK_BITS-1:0] WORK_ONE = WORK_BITS'(1);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_WRAP    = 2'd0,
        MODE_REFLECT = 2'd1,
        MODE_ROTATE  = 2'd2,
        MODE_COLOR   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE_H = 2'd0,
        REG_MODE_V = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } cfg_reg_t;

    // settings seen by one axis: its mode, its own size, the other axis size
    typedef struct packed {
        mode_t                mode;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] other;
    } axis_cfg_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/image_edge_coordinate_fold.sv -----
// Image edge coordinate fold: maps a signed (x, y) pixel coordinate into an
// image of programmed width and height, each axis with its own edge mode
// (wrap, reflect, rotate, color passthrough). x is folded first; y then
// works on the updated pair.
// Input channel: coord_x/coord_y with coord_valid; a beat is taken on a rising
// edge with coord_valid high and coord_stall low.
// Output channel: folded_x/folded_y/outside with fold_valid; a beat leaves on
// a rising edge with fold_valid high and fold_stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no beat is in flight. A size of 0 acts as 1.
// Throughput: one beat per cycle while the output is not stalled. The path from
// input beat to output beat runs through the two remainder pipelines (three
// restoring steps per stage, six stages per axis, plus an entry and a select
// stage each) and the output register.
// Stall: the whole pipeline holds while the output register is full and
// stalled; coord_stall is high exactly then. Nothing is lost or repeated.
// Reset: empties the pipeline, modes go to wrap, width and height to 1.
`default_nettype none

module image_edge_coordinate_fold (
    input  wire                                       clk,
    input  wire                                       rst_n,

    input  wire                                       cfg_valid,
    output logic                                      cfg_ready,
    input  wire [iecf_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  wire [iecf_pkg::SIZE_BITS-1:0]             cfg_data,

    input  wire                                       coord_valid,
    output logic                                      coord_stall,
    input  wire logic signed [iecf_pkg::COORD_BITS-1:0] coord_x,
    input  wire logic signed [iecf_pkg::COORD_BITS-1:0] coord_y,

    output logic                                      fold_valid,
    input  wire                                       fold_stall,
    output logic signed [iecf_pkg::OUT_BITS-1:0]      folded_x,
    output logic signed [iecf_pkg::OUT_BITS-1:0]      folded_y,
    output logic                                      outside
);

    iecf_pkg::mode_t                        mode_h_reg;
    iecf_pkg::mode_t                        mode_v_reg;
    logic [iecf_pkg::SIZE_BITS-1:0]         width_reg;
    logic [iecf_pkg::SIZE_BITS-1:0]         height_reg;
    logic [iecf_pkg::SIZE_BITS-1:0]         size_next;

    logic                                   advance;
    iecf_pkg::pipe_ctl_t                    x_ctl;
    iecf_pkg::pipe_ctl_t                    y_ctl;
    iecf_pkg::axis_cfg_t                    x_cfg;
    iecf_pkg::axis_cfg_t                    y_cfg;

    logic signed [iecf_pkg::WORK_BITS-1:0]  x_in;
    logic signed [iecf_pkg::WORK_BITS-1:0]  y_in;
    logic                                   x_valid;
    logic signed [iecf_pkg::WORK_BITS-1:0]  x_mid;
    logic signed [iecf_pkg::WORK_BITS-1:0]  y_mid;
    logic                                   y_valid;
    logic signed [iecf_pkg::WORK_BITS-1:0]  y_fin;
    logic signed [iecf_pkg::WORK_BITS-1:0]  x_fin;
    logic signed [iecf_pkg::WORK_BITS-1:0]  width_ext;
    logic signed [iecf_pkg::WORK_BITS-1:0]  height_ext;
    logic                                   outside_next;

    logic                                   fold_valid_reg;
    logic signed [iecf_pkg::OUT_BITS-1:0]   folded_x_reg;
    logic signed [iecf_pkg::OUT_BITS-1:0]   folded_y_reg;
    logic                                   outside_reg;

    // configuration registers, zero size stored as one
    assign cfg_ready = 1'b1;
    assign size_next = (cfg_data == '0) ? iecf_pkg::SIZE_BITS'(1) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_h_reg <= iecf_pkg::MODE_WRAP;
            mode_v_reg <= iecf_pkg::MODE_WRAP;
            width_reg  <= iecf_pkg::SIZE_BITS'(1);
            height_reg <= iecf_pkg::SIZE_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (iecf_pkg::cfg_reg_t'(cfg_index))
                iecf_pkg::REG_MODE_H:
                    mode_h_reg <= iecf_pkg::mode_t'(cfg_data[iecf_pkg::MODE_BITS-1:0]);
                iecf_pkg::REG_MODE_V:
                    mode_v_reg <= iecf_pkg::mode_t'(cfg_data[iecf_pkg::MODE_BITS-1:0]);
                iecf_pkg::REG_WIDTH:
                    width_reg  <= size_next;
                iecf_pkg::REG_HEIGHT:
                    height_reg <= size_next;
                default:
                begin
                end
            endcase
        end
    end

    // global pipeline enable: move unless the output beat is held
    assign advance     = !fold_valid_reg || !fold_stall;
    assign coord_stall = !advance;

    assign x_ctl = '{en: advance, valid: coord_valid};
    assign y_ctl = '{en: advance, valid: x_valid};
    assign x_cfg = '{mode: mode_h_reg, size: width_reg, other: height_reg};
    assign y_cfg = '{mode: mode_v_reg, size: height_reg, other: width_reg};

    assign x_in = iecf_pkg::WORK_BITS'(coord_x);
    assign y_in = iecf_pkg::WORK_BITS'(coord_y);

    iecf_axis u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (x_cfg),
        .ctl       (x_ctl),
        .v_in      (x_in),
        .u_in      (y_in),
        .valid_out (x_valid),
        .v_out     (x_mid),
        .u_out     (y_mid)
    );

    // y axis sees the pair after the x fold; its rotate flips x
    iecf_axis u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (y_cfg),
        .ctl       (y_ctl),
        .v_in      (y_mid),
        .u_in      (x_mid),
        .valid_out (y_valid),
        .v_out     (y_fin),
        .u_out     (x_fin)
    );

    assign width_ext  = iecf_pkg::WORK_BITS'(width_reg);
    assign height_ext = iecf_pkg::WORK_BITS'(height_reg);

    // judged on the full-width pair before truncation
    assign outside_next = x_fin[iecf_pkg::WORK_BITS-1] || (x_fin >= width_ext)
                       || y_fin[iecf_pkg::WORK_BITS-1] || (y_fin >= height_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_valid_reg <= 1'b0;
        else if (advance)
            fold_valid_reg <= y_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            folded_x_reg <= x_fin[iecf_pkg::OUT_BITS-1:0];
            folded_y_reg <= y_fin[iecf_pkg::OUT_BITS-1:0];
            outside_reg  <= outside_next;
        end
    end

    assign fold_valid = fold_valid_reg;
    assign folded_x   = folded_x_reg;
    assign folded_y   = folded_y_reg;
    assign outside    = outside_reg;

endmodule

`default_nettype wire

// ----- rtl/core/iecf_axis.sv -----
`default_nettype none

module iecf_axis (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire iecf_pkg::axis_cfg_t                cfg,
    input  wire iecf_pkg::pipe_ctl_t                ctl,
    input  wire logic signed [iecf_pkg::WORK_BITS-1:0] v_in,
    input  wire logic signed [iecf_pkg::WORK_BITS-1:0] u_in,
    output logic                                    valid_out,
    output logic signed [iecf_pkg::WORK_BITS-1:0]   v_out,
    output logic signed [iecf_pkg::WORK_BITS-1:0]   u_out
);

    logic [iecf_pkg::DIV_STAGES:0]               valid_reg;
    logic signed [iecf_pkg::WORK_BITS-1:0]       v_reg     [iecf_pkg::DIV_STAGES+1];
    logic signed [iecf_pkg::WORK_BITS-1:0]       u_reg     [iecf_pkg::DIV_STAGES+1];
    logic [iecf_pkg::PAD_BITS-1:0]               mag_reg   [iecf_pkg::DIV_STAGES+1];
    logic [iecf_pkg::SIZE_BITS-1:0]              rem_reg   [iecf_pkg::DIV_STAGES+1];
    logic [iecf_pkg::DIV_STAGES:0]               below_reg;
    logic [iecf_pkg::DIV_STAGES:0]               above_reg;

    logic signed [iecf_pkg::WORK_BITS-1:0]       size_ext;
    logic signed [iecf_pkg::WORK_BITS-1:0]       other_ext;
    logic signed [iecf_pkg::WORK_BITS-1:0]       v_neg;
    logic [iecf_pkg::MAG_BITS-1:0]               mag_abs;
    logic [iecf_pkg::PAD_BITS-1:0]               mag_next;
    logic                                        below_next;
    logic                                        above_next;

    logic signed [iecf_pkg::WORK_BITS-1:0]       m_ext;
    logic signed [iecf_pkg::WORK_BITS-1:0]       v_next;
    logic signed [iecf_pkg::WORK_BITS-1:0]       u_next;
    logic                                        flip;
    logic                                        out_valid_reg;
    logic signed [iecf_pkg::WORK_BITS-1:0]       v_out_reg;
    logic signed [iecf_pkg::WORK_BITS-1:0]       u_out_reg;

    assign size_ext  = iecf_pkg::WORK_BITS'(cfg.size);
    assign other_ext = iecf_pkg::WORK_BITS'(cfg.other);

    // entry stage: range test and magnitude for the remainder
    always_comb
    begin
        below_next = v_in[iecf_pkg::WORK_BITS-1];
        above_next = !below_next && (v_in >= size_ext);
        v_neg      = -v_in;
        mag_abs    = below_next ? v_neg[iecf_pkg::MAG_BITS-1:0]
                                : v_in[iecf_pkg::MAG_BITS-1:0];
        mag_next   = iecf_pkg::PAD_BITS'(mag_abs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg     <= {valid_reg[iecf_pkg::DIV_STAGES-1:0], ctl.valid};
            out_valid_reg <= valid_reg[iecf_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            v_reg[0]     <= v_in;
            u_reg[0]     <= u_in;
            mag_reg[0]   <= mag_next;
            rem_reg[0]   <= '0;
            below_reg[0] <= below_next;
            above_reg[0] <= above_next;
        end
    end

    // restoring remainder, most significant bits first
    for (genvar k = 1; k <= iecf_pkg::DIV_STAGES; k++)
    begin : g_div
        localparam int BASE = iecf_pkg::PAD_BITS - 1 - (k - 1) * iecf_pkg::DIV_STEP;

        logic [iecf_pkg::SIZE_BITS-1:0] r_chain [iecf_pkg::DIV_STEP+1];
        logic [iecf_pkg::SIZE_BITS-1:0] rem_next;

        assign r_chain[0] = rem_reg[k-1];

        for (genvar j = 0; j < iecf_pkg::DIV_STEP; j++)
        begin : g_step
            logic [iecf_pkg::SIZE_BITS:0] trial;
            logic [iecf_pkg::SIZE_BITS:0] diff;

            assign trial = {r_chain[j], mag_reg[k-1][BASE-j]};
            assign diff  = trial - {1'b0, cfg.size};
            assign r_chain[j+1] = (trial >= {1'b0, cfg.size})
                                  ? diff[iecf_pkg::SIZE_BITS-1:0]
                                  : trial[iecf_pkg::SIZE_BITS-1:0];
        end

        assign rem_next = r_chain[iecf_pkg::DIV_STEP];

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                v_reg[k]     <= v_reg[k-1];
                u_reg[k]     <= u_reg[k-1];
                mag_reg[k]   <= mag_reg[k-1];
                rem_reg[k]   <= rem_next;
                below_reg[k] <= below_reg[k-1];
                above_reg[k] <= above_reg[k-1];
            end
        end
    end

    // final stage: pick the folded value, flip the other axis on rotate
    always_comb
    begin
        m_ext = iecf_pkg::WORK_BITS'(rem_reg[iecf_pkg::DIV_STAGES]);
        v_next = v_reg[iecf_pkg::DIV_STAGES];
        flip   = 1'b0;
        if (below_reg[iecf_pkg::DIV_STAGES] || above_reg[iecf_pkg::DIV_STAGES])
        begin
            unique case (cfg.mode)
                iecf_pkg::MODE_WRAP:
                begin
                    if (above_reg[iecf_pkg::DIV_STAGES])
                        v_next = m_ext;
                    else if (m_ext == '0)
                        v_next = '0;
                    else
                        v_next = size_ext - m_ext;
                end
                iecf_pkg::MODE_REFLECT, iecf_pkg::MODE_ROTATE:
                begin
                    flip = (cfg.mode == iecf_pkg::MODE_ROTATE);
                    if (below_reg[iecf_pkg::DIV_STAGES])
                        v_next = m_ext;
                    else
                        v_next = size_ext - iecf_pkg::WORK_ONE - m_ext;
                end
                iecf_pkg::MODE_COLOR:
                begin
                    v_next = v_reg[iecf_pkg::DIV_STAGES];
                end
                default:
                begin
                    v_next = v_reg[iecf_pkg::DIV_STAGES];
                end
            endcase
        end
        u_next = flip ? (other_ext - iecf_pkg::WORK_ONE - u_reg[iecf_pkg::DIV_STAGES])
                      : u_reg[iecf_pkg::DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            v_out_reg <= v_next;
            u_out_reg <= u_next;
        end
    end

    assign valid_out = out_valid_reg;
    assign v_out     = v_out_reg;
    assign u_out     = u_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/iecf_checker.sv -----
`default_nettype none

module iecf_checker (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       cfg_ready,
    input  wire                                       coord_valid,
    input  wire                                       coord_stall,
    input  wire                                       fold_valid,
    input  wire                                       fold_stall,
    input  wire logic signed [iecf_pkg::OUT_BITS-1:0] folded_x,
    input  wire logic signed [iecf_pkg::OUT_BITS-1:0] folded_y,
    input  wire                                       outside
);

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fold_valid && fold_stall |=> fold_valid && $stable(folded_x)
                                     && $stable(folded_y) && $stable(outside))
        else $error("output beat changed while stalled");

    // input is only held back by a stalled output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> fold_valid && fold_stall)
        else $error("input stalled without output backpressure");

    // a pair reported inside the image has nonnegative coordinates
    a_inside_sign: assert property (@(posedge clk) disable iff (!rst_n)
        fold_valid && !outside |-> !folded_x[iecf_pkg::OUT_BITS-1]
                                   && !folded_y[iecf_pkg::OUT_BITS-1])
        else $error("inside pair has a negative coordinate");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        coord_valid && fold_valid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind image_edge_coordinate_fold iecf_checker u_iecf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .fold_valid  (fold_valid),
    .fold_stall  (fold_stall),
    .folded_x    (folded_x),
    .folded_y    (folded_y),
    .outside     (outside)
);

`default_nettype wire

// ----- dv/image_edge_coordinate_fold_tb.sv -----
`timescale 1ns / 100ps

module image_edge_coordinate_fold_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int ITEMS_PER_PHASE = 30;

    typedef struct {
        logic signed [iecf_pkg::COORD_BITS-1:0] x;
        logic signed [iecf_pkg::COORD_BITS-1:0] y;
    } coord_pair_t;

    typedef struct {
        logic signed [iecf_pkg::OUT_BITS-1:0] fx;
        logic signed [iecf_pkg::OUT_BITS-1:0] fy;
        logic                                 off_image;
    } fold_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [iecf_pkg::CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [iecf_pkg::SIZE_BITS-1:0]         cfg_data = '0;

    logic                                   coord_valid = 1'b0;
    logic                                   coord_stall;
    logic signed [iecf_pkg::COORD_BITS-1:0] coord_x = '0;
    logic signed [iecf_pkg::COORD_BITS-1:0] coord_y = '0;

    logic                                   fold_valid;
    logic                                   fold_stall = 1'b0;
    logic signed [iecf_pkg::OUT_BITS-1:0]   folded_x;
    logic signed [iecf_pkg::OUT_BITS-1:0]   folded_y;
    logic                                   outside;

    // register copies used by the predictor
    iecf_pkg::mode_t                h_mode = iecf_pkg::MODE_WRAP;
    iecf_pkg::mode_t                v_mode = iecf_pkg::MODE_WRAP;
    logic [iecf_pkg::SIZE_BITS-1:0] width_reg = iecf_pkg::SIZE_BITS'(1);
    logic [iecf_pkg::SIZE_BITS-1:0] height_reg = iecf_pkg::SIZE_BITS'(1);

    coord_pair_t  pending_coords[$];
    fold_result_t expected_folds[$];
    coord_pair_t  next_pair;
    fold_result_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int fold_errors = 0;
    int quiet_cycles = 0;

    image_edge_coordinate_fold DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .fold_valid  (fold_valid),
        .fold_stall  (fold_stall),
        .folded_x    (folded_x),
        .folded_y    (folded_y),
        .outside     (outside)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint edge_fold(input longint v, input longint size,
                                         input iecf_pkg::mode_t mode, output bit flip);
        longint m;
        flip = 1'b0;
        if (mode == iecf_pkg::MODE_COLOR)
            return v;
        if (v < 0)
        begin
            m = (-v) % size;
            if (mode == iecf_pkg::MODE_WRAP)
                return (m == 0) ? longint'(0) : size - m;
            flip = (mode == iecf_pkg::MODE_ROTATE);
            return m;
        end
        if (v >= size)
        begin
            m = v % size;
            if (mode == iecf_pkg::MODE_WRAP)
                return m;
            flip = (mode == iecf_pkg::MODE_ROTATE);
            return (size - 1) - m;
        end
        return v;
    endfunction

    function automatic fold_result_t predict_fold(
        input logic signed [iecf_pkg::COORD_BITS-1:0] cx,
        input logic signed [iecf_pkg::COORD_BITS-1:0] cy);
        longint       w;
        longint       h;
        longint       x;
        longint       y;
        bit           flip;
        fold_result_t r;
        w = (width_reg == '0) ? longint'(1) : longint'(width_reg);
        h = (height_reg == '0) ? longint'(1) : longint'(height_reg);
        x = longint'(cx);
        y = longint'(cy);
        x = edge_fold(x, w, h_mode, flip);
        if (flip)
            y = (h - 1) - y;
        y = edge_fold(y, h, v_mode, flip);
        if (flip)
            x = (w - 1) - x;
        r.fx = x[iecf_pkg::OUT_BITS-1:0];
        r.fy = y[iecf_pkg::OUT_BITS-1:0];
        r.off_image = (x < 0 || x >= w || y < 0 || y >= h);
        return r;
    endfunction

    // coordinates biased toward the image and its edges, plus full-range noise
    function automatic logic signed [iecf_pkg::COORD_BITS-1:0] rand_coord(input int s);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 6 * s) - 3 * s;
            6, 7:       v = (s <= 1) ? 0 : $urandom_range(0, s - 1);
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       v = -s;
                    1:       v = s;
                    2:       v = -1;
                    3:       v = s - 1;
                    4:       v = -2 * s;
                    default: v = 2 * s - 1;
                endcase
            end
            default:    v = $urandom_range(0, 1) ? -32768 : 32767;
        endcase
        return v[iecf_pkg::COORD_BITS-1:0];
    endfunction

    function automatic logic [iecf_pkg::SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return iecf_pkg::SIZE_BITS'(1);
            2:       return iecf_pkg::SIZE_BITS'(8192);
            3:       return iecf_pkg::SIZE_BITS'(16383);
            4:       return iecf_pkg::SIZE_BITS'($urandom_range(2, 64));
            default: return iecf_pkg::SIZE_BITS'($urandom_range(1, 16383));
        endcase
    endfunction

    task automatic push_pair(input longint x, input longint y);
        coord_pair_t p;
        p.x = x[iecf_pkg::COORD_BITS-1:0];
        p.y = y[iecf_pkg::COORD_BITS-1:0];
        pending_coords.push_back(p);
    endtask

    task automatic write_reg(input iecf_pkg::cfg_reg_t idx,
                             input logic [iecf_pkg::SIZE_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            iecf_pkg::REG_MODE_H: h_mode = iecf_pkg::mode_t'(data[iecf_pkg::MODE_BITS-1:0]);
            iecf_pkg::REG_MODE_V: v_mode = iecf_pkg::mode_t'(data[iecf_pkg::MODE_BITS-1:0]);
            iecf_pkg::REG_WIDTH:  width_reg = data;
            iecf_pkg::REG_HEIGHT: height_reg = data;
        endcase
    endtask

    // upper data bits of mode writes are random and must be ignored
    task automatic set_config(input iecf_pkg::mode_t mh, input iecf_pkg::mode_t mv,
                              input logic [iecf_pkg::SIZE_BITS-1:0] w,
                              input logic [iecf_pkg::SIZE_BITS-1:0] h);
        logic [iecf_pkg::SIZE_BITS-1:0] junk;
        junk = iecf_pkg::SIZE_BITS'($urandom);
        write_reg(iecf_pkg::REG_MODE_H, {junk[iecf_pkg::SIZE_BITS-1:iecf_pkg::MODE_BITS], mh});
        junk = iecf_pkg::SIZE_BITS'($urandom);
        write_reg(iecf_pkg::REG_MODE_V, {junk[iecf_pkg::SIZE_BITS-1:iecf_pkg::MODE_BITS], mv});
        write_reg(iecf_pkg::REG_WIDTH, w);
        write_reg(iecf_pkg::REG_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_coords.size() != 0 || coord_valid || expected_folds.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_edge_cases(input longint w, input longint h);
        push_pair(0, 0);
        push_pair(w - 1, h - 1);
        push_pair(w, h);
        push_pair(-1, -1);
        push_pair(-w, -h);
        push_pair(-32768, 32767);
        push_pair(32767, -32768);
        push_pair(-2 * w, 2 * h - 1);
    endtask

    // driver: input beat taken when valid and not stalled
    always @(posedge clk)
    begin
        if (coord_valid && !coord_stall)
            expected_folds.push_back(predict_fold(coord_x, coord_y));
        if (!coord_valid || !coord_stall)
        begin
            if (pending_coords.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_pair = pending_coords.pop_front();
                coord_valid <= 1'b1;
                coord_x <= next_pair.x;
                coord_y <= next_pair.y;
            end
            else
            begin
                coord_valid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted down in cycles
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor and receiver stall generation
    always @(posedge clk)
    begin
        if (fold_valid && !fold_stall)
        begin
            if (expected_folds.size() == 0)
            begin
                $error("unexpected beat: folded_x=%0d folded_y=%0d outside=%0b",
                       folded_x, folded_y, outside);
                fold_errors++;
            end
            else
            begin
                want = expected_folds.pop_front();
                if (folded_x !== want.fx)
                begin
                    $error("folded_x expected %0d got %0d", want.fx, folded_x);
                    fold_errors++;
                end
                if (folded_y !== want.fy)
                begin
                    $error("folded_y expected %0d got %0d", want.fy, folded_y);
                    fold_errors++;
                end
                if (outside !== want.off_image)
                begin
                    $error("outside expected %0b got %0b", want.off_image, outside);
                    fold_errors++;
                end
            end
        end
        if (hold_left > 0)
        begin
            fold_stall <= 1'b1;
        end
        else
        begin
            fold_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (coord_valid && !coord_stall) || (fold_valid && !fold_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [iecf_pkg::SIZE_BITS-1:0] w;
        logic [iecf_pkg::SIZE_BITS-1:0] h;
        int ws;
        int hs;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: negative wrap onto the size, zero size, sizes above 8192
        set_config(iecf_pkg::MODE_WRAP, iecf_pkg::MODE_COLOR,
                   iecf_pkg::SIZE_BITS'(5), iecf_pkg::SIZE_BITS'(7));
        push_edge_cases(5, 7);
        wait_idle();
        set_config(iecf_pkg::MODE_ROTATE, iecf_pkg::MODE_REFLECT,
                   '0, iecf_pkg::SIZE_BITS'(16383));
        push_edge_cases(1, 16383);
        wait_idle();
        set_config(iecf_pkg::MODE_REFLECT, iecf_pkg::MODE_ROTATE,
                   iecf_pkg::SIZE_BITS'(8192), iecf_pkg::SIZE_BITS'(3));
        push_edge_cases(8192, 3);
        wait_idle();

        for (int k = 0; k < 16; k++)
        begin
            case (k % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (k)
                0:
                begin
                    w = '0;
                    h = iecf_pkg::SIZE_BITS'(16383);
                end
                1:
                begin
                    w = iecf_pkg::SIZE_BITS'(16383);
                    h = '0;
                end
                2:
                begin
                    w = iecf_pkg::SIZE_BITS'(8192);
                    h = iecf_pkg::SIZE_BITS'(1);
                end
                3:
                begin
                    w = iecf_pkg::SIZE_BITS'(1);
                    h = iecf_pkg::SIZE_BITS'(8192);
                end
                default: begin w = pick_size(); h = pick_size(); end
            endcase
            set_config(iecf_pkg::mode_t'(k[1:0]), iecf_pkg::mode_t'(k[3:2]), w, h);
            ws = (w == '0) ? 1 : int'(w);
            hs = (h == '0) ? 1 : int'(h);
            // long receiver hold while the sender keeps offering beats
            if (k == 4)
                hold_request = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_pair(longint'(rand_coord(ws)), longint'(rand_coord(hs)));
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (fold_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/iecf_pkg.sv
rtl/core/iecf_axis.sv
rtl/core/image_edge_coordinate_fold.sv
rtl/core/iecf_checker.sv
dv/image_edge_coordinate_fold_tb.sv
